// File: sv/rcf_pkg.sv
// rcf_pkg: shared constants and the coefficient function for the raised-cosine fir
// holds the q1.31 master kernel, output limits and the per-tap coefficient rounding
// used by raised_cosine_fir_with_peak and its cells; depends on nothing
package rcf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int OUT_W       = 18;
    localparam int PEAK_W      = 15;
    localparam int KERNEL_LEN  = 36;
    localparam int KERNEL_HALF = 18;
    localparam int OUT_MAX     = 131071;
    localparam int OUT_MIN     = -131072;
    // master values below this become zero taps
    localparam int SMALL_LIMIT = 32768;

    typedef logic [31:0] master_t;

    // first half of the symmetric kernel, q1.31
    localparam master_t HALF_KERNEL [KERNEL_HALF] = '{
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd7950, 32'd480070, 32'd12766361, 32'd149499222,
        32'd770925155, 32'd1750671620
    };

    // coefficient for tap k (k = 0 pairs with the oldest sample)
    function automatic int rcf_coef(input int k, input int taps, input int coef_width);
        int      j;
        int      sh;
        longint  m;
        j  = k + KERNEL_HALF - (taps >> 1);
        sh = 32 - coef_width;
        if (j < 0 || j >= KERNEL_LEN)
            return 0;
        if (j < KERNEL_HALF)
            m = longint'(HALF_KERNEL[j]);
        else
            m = longint'(HALF_KERNEL[KERNEL_LEN - 1 - j]);
        if (m < longint'(SMALL_LIMIT))
            return 0;
        return int'((m + (longint'(1) << (sh - 1))) >>> sh);
    endfunction

endpackage

// File: sv/rcf_cell.sv
// rcf_cell: one tap of the transposed fir chain
// multiplies the incoming sample by its fixed coefficient and adds the neighbor's
// partial sum; uses rcf_pkg for the sample width
module rcf_cell #(
    parameter int ACC_W      = 40,
    parameter int COEF_WIDTH = 16,
    parameter logic signed [COEF_WIDTH-1:0] COEF = '0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic signed [rcf_pkg::SAMPLE_W-1:0] x,
    input  logic signed [ACC_W-1:0]             sum_in,
    output logic signed [ACC_W-1:0]             sum_out
);
    import rcf_pkg::*;

    logic signed [SAMPLE_W+COEF_WIDTH-1:0] prod;
    logic signed [ACC_W-1:0]               sum_reg;
    logic signed [ACC_W-1:0]               sum_next;

    always_comb
    begin
        prod     = x * COEF;
        sum_next = sum_in + ACC_W'(prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (advance)
            sum_reg <= sum_next;
    end

    assign sum_out = sum_reg;

endmodule

// File: sv/rcf_out.sv
// rcf_out: output stage of the raised-cosine fir
// rounds and saturates the finished sum, tracks the running peak, and holds the
// output item register; uses rcf_pkg for widths and limits
module rcf_out #(
    parameter int ACC_W      = 40,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                take,
    input  logic signed [ACC_W-1:0]             acc,
    input  logic signed [rcf_pkg::SAMPLE_W-1:0] x,
    input  logic                                clear_peak,
    output logic                                valid,
    output logic signed [rcf_pkg::OUT_W-1:0]    filtered,
    output logic        [rcf_pkg::PEAK_W-1:0]   peak
);
    import rcf_pkg::*;

    localparam int FRAC = COEF_WIDTH - 1;
    localparam logic signed [ACC_W:0] HI = signed'((ACC_W+1)'(OUT_MAX));
    localparam logic signed [ACC_W:0] LO = signed'((ACC_W+1)'(OUT_MIN));
    localparam logic signed [ACC_W:0] HALF = signed'((ACC_W+1)'(1) << (FRAC - 1));

    logic signed [ACC_W:0]    biased;
    logic signed [ACC_W:0]    shifted;
    logic signed [OUT_W-1:0]  filt_next;
    logic [PEAK_W-1:0]        base;
    logic [PEAK_W-1:0]        peak_next;
    logic [PEAK_W-1:0]        peak_reg;
    logic                     valid_reg;
    logic signed [OUT_W-1:0]  filt_reg;
    logic [PEAK_W-1:0]        peak_out_reg;

    always_comb
    begin
        // floor shift of the biased sum gives round half up
        biased  = signed'((ACC_W+1)'(acc)) + HALF;
        shifted = biased >>> FRAC;
        if (shifted > HI)
            filt_next = OUT_W'(OUT_MAX);
        else if (shifted < LO)
            filt_next = OUT_W'(OUT_MIN);
        else
            filt_next = shifted[OUT_W-1:0];

        base = clear_peak ? '0 : peak_reg;
        if (x > signed'({1'b0, base}))
            peak_next = x[PEAK_W-1:0];
        else
            peak_next = base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                peak_reg  <= peak_next;
                valid_reg <= 1'b1;
            end
            else if (take)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            filt_reg     <= filt_next;
            peak_out_reg <= peak_next;
        end
    end

    assign valid    = valid_reg;
    assign filtered = filt_reg;
    assign peak     = peak_out_reg;

endmodule

// File: sv/raised_cosine_fir_with_peak.sv
// raised_cosine_fir_with_peak: 36-tap raised-cosine fir with running input peak
// an item's result is registered on the same edge that accepts the item
// throughput: one item per cycle while the output is read, set by the single multiply-add in each chain cell
// a result waiting on out_ready holds off the input; the next item is taken when it is read
// reset clears all partial sums (empty delay line), the running peak and out_valid
// depends on rcf_pkg, rcf_cell and rcf_out
module raised_cosine_fir_with_peak #(
    parameter int TAPS       = 36,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rcf_pkg::SAMPLE_W-1:0] sample,
    input  logic                                chunk_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rcf_pkg::OUT_W-1:0]    filtered,
    output logic        [rcf_pkg::PEAK_W-1:0]   peak
);
    import rcf_pkg::*;

    localparam int ACC_W = SAMPLE_W + COEF_WIDTH + $clog2(TAPS) + 1;

    logic                    advance;
    logic                    take;
    logic signed [ACC_W-1:0] sums [TAPS+1];

    assign take     = out_valid && out_ready;
    assign in_ready = !out_valid || out_ready;
    assign advance  = in_valid && in_ready;

    assign sums[TAPS] = '0;

    // cell k holds the sum that is output when k+1 more items have been accepted
    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        rcf_cell #(
            .ACC_W      (ACC_W),
            .COEF_WIDTH (COEF_WIDTH),
            .COEF       (COEF_WIDTH'(rcf_coef(TAPS - 1 - k, TAPS, COEF_WIDTH)))
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .x       (sample),
            .sum_in  (sums[k+1]),
            .sum_out (sums[k])
        );
    end

    rcf_out #(
        .ACC_W      (ACC_W),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .take       (take),
        .acc        (sums[0]),
        .x          (sample),
        .clear_peak (chunk_start),
        .valid      (out_valid),
        .filtered   (filtered),
        .peak       (peak)
    );

endmodule

// File: sv/rcf_checker.sv
// rcf_checker: port-level assertions for raised_cosine_fir_with_peak
// watches the handshakes and the peak output; bound to the top level below
module rcf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [15:0] sample,
    input logic               chunk_start,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [17:0] filtered,
    input logic        [14:0] peak
);

    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(peak))
        else $error("output item changed while stalled");

    // every accepted item produces a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item gave no result");

    // a waiting result blocks the input
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output full");

    // chunk start with a negative sample leaves the peak at its floor
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && chunk_start && sample[15] |=> peak == 15'd0)
        else $error("peak not cleared at chunk start");

endmodule

bind raised_cosine_fir_with_peak rcf_checker u_rcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .chunk_start (chunk_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .filtered    (filtered),
    .peak        (peak)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for raised_cosine_fir_with_peak, 36-tap fir plus input peak
// predicts every result from its own delay line, tap table and peak register
// depends on rcf_pkg and the raised_cosine_fir_with_peak rtl
module tb;

    import rcf_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       cs;
    } fir_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filt;
        logic [PEAK_W-1:0]       pk;
    } fir_result_t;

    localparam int NTAPS     = 36;
    localparam int FRAC      = 15;
    localparam int RAND_EACH = 545;

    // q1.31 master values, first half of the kernel, the rest mirrors it
    localparam longint MASTER_HALF [KERNEL_HALF] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        7950, 480070, 12766361, 149499222, 770925155, 1750671620
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic chunk_start = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [OUT_W-1:0] filtered;
    logic [PEAK_W-1:0] peak;

    fir_item_t   pending_samples[$];
    fir_result_t expected_outputs[$];

    int  tap_coef [NTAPS];
    logic signed [SAMPLE_W-1:0] history [NTAPS];
    logic [PEAK_W-1:0] peak_seen;

    int   mismatches = 0;
    int   phase = 0;
    int   send_idle_pct = 25;
    int   recv_idle_pct = 70;
    logic hold_off = 1'b0;
    logic in_taken = 1'b0;

    raised_cosine_fir_with_peak dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .chunk_start(chunk_start),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .filtered   (filtered),
        .peak       (peak)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // filter output over the previous samples, then shift in the new one and update the peak
    function automatic fir_result_t fir_predict(input fir_item_t it);
        fir_result_t r;
        longint      acc;
        longint      y;
        acc = 0;
        for (int k = 0; k < NTAPS; k++)
            acc += longint'(history[k]) * longint'(tap_coef[NTAPS-1-k]);
        y = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
        if (y > OUT_MAX)
            y = OUT_MAX;
        if (y < OUT_MIN)
            y = OUT_MIN;
        for (int k = NTAPS - 1; k > 0; k--)
            history[k] = history[k-1];
        history[0] = it.smp;
        if (it.cs)
            peak_seen = '0;
        if (int'(it.smp) > int'(peak_seen))
            peak_seen = it.smp[PEAK_W-1:0];
        r.filt = y[OUT_W-1:0];
        r.pk   = peak_seen;
        return r;
    endfunction

    task automatic add_item(input int s, input bit cs);
        fir_item_t it;
        it.smp = s[SAMPLE_W-1:0];
        it.cs  = cs;
        pending_samples.push_back(it);
    endtask

    // mostly uniform or small samples; full-length runs of one value drive the sum to extremes
    task automatic queue_random(input int n);
        int cnt;
        int r;
        int len;
        int v;
        cnt = 0;
        while (cnt < n) begin
            r = $urandom_range(99);
            if (r < 15) begin
                len = $urandom_range(36, 44);
                case ($urandom_range(2))
                    0: v = 32767;
                    1: v = -32768;
                    default: v = int'($signed($urandom_range(65535) - 32768));
                endcase
                for (int i = 0; i < len; i++)
                    add_item(v, $urandom_range(39) == 0);
                cnt += len;
            end
            else if (r < 30) begin
                add_item(int'($urandom_range(127)) - 64, $urandom_range(19) == 0);
                cnt++;
            end
            else begin
                add_item(int'($urandom_range(65535)) - 32768, $urandom_range(24) == 0);
                cnt++;
            end
        end
    endtask

    // result check and prediction on accepted items
    always @(posedge clk)
    begin : watch
        fir_result_t want;
        in_taken = in_valid && in_ready;
        if (rst_n && out_valid && out_ready) begin
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: filtered %0d peak %0d", filtered, peak);
            end
            else begin
                want = expected_outputs.pop_front();
                if (filtered !== want.filt || peak !== want.pk) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: filtered exp %0d got %0d, peak exp %0d got %0d",
                                 want.filt, filtered, want.pk, peak);
                end
            end
        end
        if (in_taken)
            expected_outputs.push_back(fir_predict('{smp: sample, cs: chunk_start}));
    end

    always @(negedge clk)
    begin : drive
        fir_item_t nxt;
        if (!in_valid || in_taken) begin
            if (rst_n && pending_samples.size() != 0
                && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_samples.pop_front();
                sample      <= nxt.smp;
                chunk_start <= nxt.cs;
                in_valid    <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver stall while the sender keeps offering items
    initial
    begin
        wait (phase == 2);
        repeat (60) @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int sh;
        longint m;
        sh = 32 - 16;
        for (int k = 0; k < NTAPS; k++) begin
            m = (k < KERNEL_HALF) ? MASTER_HALF[k] : MASTER_HALF[KERNEL_LEN-1-k];
            tap_coef[k] = (m < SMALL_LIMIT) ? 0 : int'((m + (longint'(1) << (sh - 1))) >>> sh);
        end
        for (int k = 0; k < NTAPS; k++)
            history[k] = '0;
        peak_seen = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // field extremes, peak clears, negatives after a clear
        add_item(32767, 1);
        add_item(-32768, 0);
        add_item(0, 0);
        add_item(-1, 0);
        add_item(1, 0);
        add_item(16384, 0);
        add_item(-32768, 1);
        add_item(-5, 0);
        add_item(-1, 0);
        add_item(100, 1);
        add_item(50, 0);
        add_item(32767, 0);
        add_item(0, 1);
        add_item(-32768, 0);
        add_item(21845, 0);
        add_item(-21846, 0);
        add_item(255, 0);
        add_item(-256, 1);
        add_item(12345, 0);
        add_item(-12345, 0);
        add_item(1, 1);
        add_item(32766, 0);
        add_item(-2, 0);
        queue_random(RAND_EACH);
        wait (pending_samples.size() == 0 && expected_outputs.size() == 0);
        @(posedge clk);
        phase = 1;
        send_idle_pct = 70;
        recv_idle_pct = 25;
        queue_random(RAND_EACH);
        wait (pending_samples.size() == 0 && expected_outputs.size() == 0);
        @(posedge clk);
        phase = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(RAND_EACH);
        wait (pending_samples.size() == 0 && expected_outputs.size() == 0 && !hold_off);
        repeat (10) @(posedge clk);
        if (expected_outputs.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
